/* hdl/kci_pkg.sv */
// Shared types and constants for the keyframe color interpolator.
package kci_pkg;

    localparam int LED_COUNT_DEF    = 256;
    localparam int KEYS_PER_LED_DEF = 16;

    localparam logic [1:0] REQ_BEGIN  = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_RENDER = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  led_index;
        logic [3:0]  point_index;
        logic [31:0] key_time;
        logic [7:0]  shape_code;
        logic [7:0]  key_red;
        logic [7:0]  key_green;
        logic [7:0]  key_blue;
        logic [31:0] time_shift;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [7:0] out_led;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       color_valid;
    } rsp_t;

    typedef struct packed {
        logic [31:0] ktime;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        active;
    } key_entry_t;

    localparam int KEY_ENTRY_W = $bits(key_entry_t);

    typedef struct packed {
        logic        start;
        logic [5:0]  steps;
        logic [31:0] rem_init;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

endpackage

/* hdl/kci_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
module kci_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/kci_div.sv */
// Iterative restoring divider, one quotient bit per cycle, preloadable remainder.
module kci_div import kci_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t cmd,
    output div_rsp_t rsp
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] sh_reg, sh_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, sh_reg[31]};
        diff  = trial - {1'b0, div_reg};
        ge    = trial >= {1'b0, div_reg};

        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = run_reg && (cnt_reg == 6'd1);

        if (cmd.start)
        begin
            rem_next = cmd.rem_init;
            sh_next  = cmd.dividend;
            q_next   = '0;
            div_next = cmd.divisor;
            cnt_next = cmd.steps;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // partial remainder stays below the divisor, so 32 bits hold it
            rem_next = ge ? diff[31:0] : trial[31:0];
            sh_next  = {sh_reg[30:0], 1'b0};
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign rsp = '{done: done_reg, quot: q_reg, rem: rem_reg};

endmodule

/* hdl/keyframe_color_interpolator.sv */
// Top level: per-LED keyframe tables, render sequencer and interpolation.
//
//  channel   signals                 direction  handshake
//  request   start, busy, request    in         beat taken when start && !busy
//  result    strobe, result          out        one-cycle beat, cannot be held off
//
// A write passes through a single write state; begin writes the shift through the
// shift RAM port and sweeps a keyframe clear through the keyframe RAM port.
// A render runs up to two keyframe scans at one RAM read a cycle, a 32-step modulo
// and three 8-step channel divisions in the shared divider; the modulo is skipped
// when the loop period is 0.
// After reset a clearing pass over all LED_COUNT*KEYS_PER_LED slots holds busy high.
// The result side cannot stall; each result is flagged by a one-cycle strobe.
module keyframe_color_interpolator import kci_pkg::*; #(
    parameter int LED_COUNT    = LED_COUNT_DEF,
    parameter int KEYS_PER_LED = KEYS_PER_LED_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic strobe,
    output rsp_t result
);

    localparam int SLOTS  = LED_COUNT * KEYS_PER_LED;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CNT_W  = $clog2(KEYS_PER_LED + 1);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_BEGIN    = 4'd2;
    localparam logic [3:0] ST_WRITE    = 4'd3;
    localparam logic [3:0] ST_SCAN1    = 4'd4;
    localparam logic [3:0] ST_MUL      = 4'd5;
    localparam logic [3:0] ST_MOD_GO   = 4'd6;
    localparam logic [3:0] ST_MOD_WAIT = 4'd7;
    localparam logic [3:0] ST_SCAN2    = 4'd8;
    localparam logic [3:0] ST_PREP     = 4'd9;
    localparam logic [3:0] ST_BL_MUL   = 4'd10;
    localparam logic [3:0] ST_BL_GO    = 4'd11;
    localparam logic [3:0] ST_BL_WAIT  = 4'd12;
    localparam logic [3:0] ST_FINISH   = 4'd13;

    // control
    logic [3:0]        state_reg, state_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              rv_reg, rv_next;
    logic [CNT_W-1:0]  rv_idx_reg, rv_idx_next;
    logic [1:0]        ch_reg, ch_next;
    logic              strobe_reg, strobe_next;
    logic              open_reg, open_next;
    logic              found_reg, found_next;
    logic              hit0_reg, hit0_next;
    logic              valid_reg, valid_next;

    // payload
    req_t              req_reg, req_next;
    logic [SLOT_W-1:0] base_reg, base_next;
    logic              act0_reg, act0_next;
    logic [31:0]       period_reg, period_next;
    logic [31:0]       prod_reg, prod_next;
    logic [31:0]       phase_reg, phase_next;
    key_entry_t        prev_reg, prev_next;
    key_entry_t        pv_reg, pv_next;
    key_entry_t        nx_reg, nx_next;
    logic [31:0]       num_reg, num_next;
    logic [31:0]       den_reg, den_next;
    logic [31:0]       dmn_reg, dmn_next;
    logic [39:0]       m1_reg, m1_next;
    logic [39:0]       m2_reg, m2_next;
    logic [7:0]        red_reg, red_next;
    logic [7:0]        green_reg, green_next;
    logic [7:0]        blue_reg, blue_next;
    rsp_t              result_reg, result_next;

    // memories and divider
    logic                   key_we, key_re;
    logic [SLOT_W-1:0]      key_waddr, key_raddr;
    logic [KEY_ENTRY_W-1:0] key_wdata, key_rdata;
    key_entry_t             key_rd;
    logic                   sh_we, sh_re;
    logic [LED_W-1:0]       sh_waddr;
    logic [31:0]            sh_wdata, sh_rdata;
    logic [LED_W-1:0]       led_addr;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    logic        in_led_ok;
    logic        in_pt_ok;
    logic [39:0] top_sum;
    logic [7:0]  ch_a, ch_b;
    logic        last_idx;
    key_entry_t  wr_entry;

    kci_ram #(
        .WIDTH  (KEY_ENTRY_W),
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kci_ram #(
        .WIDTH  (32),
        .DEPTH  (LED_COUNT),
        .ADDR_W (LED_W)
    ) u_shift_ram (
        .clk   (clk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .re    (sh_re),
        .raddr (led_addr),
        .rdata (sh_rdata)
    );

    kci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_req),
        .rsp   (div_rsp)
    );

    assign key_rd   = key_entry_t'(key_rdata);
    assign led_addr = LED_W'(req_reg.led_index);
    assign last_idx = (rv_idx_reg == CNT_W'(KEYS_PER_LED - 1));
    assign top_sum  = m1_reg + m2_reg;

    always_comb
    begin
        in_led_ok = 32'(request.led_index) < 32'(LED_COUNT);
        in_pt_ok  = 32'(request.point_index) < 32'(KEYS_PER_LED);

        wr_entry.ktime  = req_reg.key_time;
        wr_entry.red    = req_reg.key_red;
        wr_entry.green  = req_reg.key_green;
        wr_entry.blue   = req_reg.key_blue;
        wr_entry.active = (req_reg.shape_code != 8'd0);

        case (ch_reg)
            2'd0:
            begin
                ch_a = pv_reg.red;
                ch_b = nx_reg.red;
            end
            2'd1:
            begin
                ch_a = pv_reg.green;
                ch_b = nx_reg.green;
            end
            default:
            begin
                ch_a = pv_reg.blue;
                ch_b = nx_reg.blue;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        iss_next    = iss_reg;
        rv_next     = 1'b0;
        rv_idx_next = iss_reg;
        ch_next     = ch_reg;
        strobe_next = 1'b0;
        open_next   = open_reg;
        found_next  = found_reg;
        hit0_next   = hit0_reg;
        valid_next  = valid_reg;

        req_next    = req_reg;
        base_next   = base_reg;
        act0_next   = act0_reg;
        period_next = period_reg;
        prod_next   = prod_reg;
        phase_next  = phase_reg;
        prev_next   = prev_reg;
        pv_next     = pv_reg;
        nx_next     = nx_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        dmn_next    = dmn_reg;
        m1_next     = m1_reg;
        m2_next     = m2_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        result_next = result_reg;

        key_we    = 1'b0;
        key_waddr = base_reg + SLOT_W'(iss_reg);
        key_wdata = '0;
        key_re    = 1'b0;
        key_raddr = base_reg + SLOT_W'(iss_reg);
        sh_we     = 1'b0;
        sh_waddr  = led_addr;
        sh_wdata  = req_reg.time_shift;
        sh_re     = 1'b0;

        div_req          = '0;
        div_req.divisor  = period_reg;
        div_req.dividend = req_reg.now_ms - prod_reg;
        div_req.steps    = 6'd32;

        case (state_reg)
            ST_CLEAR:
            begin
                key_we    = 1'b1;
                key_waddr = clr_reg;
                if (32'(clr_reg) < 32'(LED_COUNT))
                begin
                    sh_we    = 1'b1;
                    sh_waddr = LED_W'(clr_reg);
                    sh_wdata = '0;
                end
                if (clr_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + SLOT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    base_next  = SLOT_W'(32'(request.led_index) * 32'(KEYS_PER_LED));
                    iss_next   = '0;
                    found_next = 1'b0;
                    hit0_next  = 1'b0;
                    valid_next = 1'b0;
                    red_next   = '0;
                    green_next = '0;
                    blue_next  = '0;
                    case (request.req_type)
                        REQ_BEGIN:
                        begin
                            if (in_led_ok)
                            begin
                                state_next = ST_BEGIN;
                            end
                        end
                        REQ_WRITE:
                        begin
                            if (in_led_ok && in_pt_ok)
                            begin
                                state_next = ST_WRITE;
                            end
                        end
                        REQ_RENDER:
                        begin
                            state_next = in_led_ok ? ST_SCAN1 : ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_BEGIN:
            begin
                key_we = 1'b1;
                sh_we  = (iss_reg == '0);
                if (iss_reg == CNT_W'(KEYS_PER_LED - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
            end

            ST_WRITE:
            begin
                key_we     = 1'b1;
                key_waddr  = base_reg + SLOT_W'(req_reg.point_index);
                key_wdata  = wr_entry;
                state_next = ST_IDLE;
            end

            ST_SCAN1:
            begin
                // pass one: period from the run of active keyframes
                sh_re = (iss_reg == '0);
                if (32'(iss_reg) < 32'(KEYS_PER_LED))
                begin
                    key_re   = 1'b1;
                    iss_next = iss_reg + CNT_W'(1);
                    rv_next  = 1'b1;
                end
                if (rv_reg)
                begin
                    if (rv_idx_reg == '0)
                    begin
                        act0_next   = key_rd.active;
                        period_next = key_rd.ktime;
                        open_next   = 1'b1;
                    end
                    else if (open_reg)
                    begin
                        if (key_rd.active)
                        begin
                            period_next = key_rd.ktime;
                        end
                        else
                        begin
                            open_next = 1'b0;
                        end
                    end
                    if (last_idx)
                    begin
                        iss_next   = '0;
                        rv_next    = 1'b0;
                        state_next = act0_reg ? ST_MUL : ST_FINISH;
                    end
                end
            end

            ST_MUL:
            begin
                prod_next = 32'(sh_rdata * 32'(req_reg.led_index));
                if (period_reg == '0)
                begin
                    phase_next = '0;
                    state_next = ST_SCAN2;
                end
                else
                begin
                    state_next = ST_MOD_GO;
                end
            end

            ST_MOD_GO:
            begin
                div_req.start = 1'b1;
                state_next    = ST_MOD_WAIT;
            end

            ST_MOD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    phase_next = div_rsp.rem;
                    state_next = ST_SCAN2;
                end
            end

            ST_SCAN2:
            begin
                // pass two: first keyframe later than the phase, with its predecessor
                if (32'(iss_reg) < 32'(KEYS_PER_LED))
                begin
                    key_re   = 1'b1;
                    iss_next = iss_reg + CNT_W'(1);
                    rv_next  = 1'b1;
                end
                if (rv_reg)
                begin
                    prev_next = key_rd;
                    if (!found_reg && (key_rd.ktime > phase_reg))
                    begin
                        found_next = 1'b1;
                        hit0_next  = (rv_idx_reg == '0);
                        pv_next    = prev_reg;
                        nx_next    = key_rd;
                    end
                    if (last_idx)
                    begin
                        iss_next   = '0;
                        rv_next    = 1'b0;
                        state_next = ST_PREP;
                    end
                end
            end

            ST_PREP:
            begin
                if (!found_reg || hit0_reg || !pv_reg.active || !nx_reg.active)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (nx_reg.ktime == pv_reg.ktime)
                    begin
                        num_next = 32'd1;
                        den_next = 32'd1;
                        dmn_next = '0;
                    end
                    else
                    begin
                        num_next = phase_reg - pv_reg.ktime;
                        den_next = nx_reg.ktime - pv_reg.ktime;
                        dmn_next = nx_reg.ktime - phase_reg;
                    end
                    valid_next = 1'b1;
                    ch_next    = '0;
                    state_next = ST_BL_MUL;
                end
            end

            ST_BL_MUL:
            begin
                // a*den + (b-a)*num rewritten as a*(den-num) + b*num, never negative
                m1_next    = 40'(ch_a) * 40'(dmn_reg);
                m2_next    = 40'(ch_b) * 40'(num_reg);
                state_next = ST_BL_GO;
            end

            ST_BL_GO:
            begin
                // quotient fits 8 bits, so the upper part already sits below den
                div_req.start    = 1'b1;
                div_req.steps    = 6'd8;
                div_req.rem_init = top_sum[39:8];
                div_req.dividend = {top_sum[7:0], 24'd0};
                div_req.divisor  = den_reg;
                state_next       = ST_BL_WAIT;
            end

            ST_BL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (ch_reg)
                        2'd0:    red_next   = div_rsp.quot[7:0];
                        2'd1:    green_next = div_rsp.quot[7:0];
                        default: blue_next  = div_rsp.quot[7:0];
                    endcase
                    if (ch_reg == 2'd2)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_BL_MUL;
                    end
                end
            end

            ST_FINISH:
            begin
                strobe_next             = 1'b1;
                result_next.out_led     = req_reg.led_index;
                result_next.out_red     = valid_reg ? red_reg : 8'd0;
                result_next.out_green   = valid_reg ? green_reg : 8'd0;
                result_next.out_blue    = valid_reg ? blue_reg : 8'd0;
                result_next.color_valid = valid_reg;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            iss_reg    <= '0;
            rv_reg     <= 1'b0;
            rv_idx_reg <= '0;
            ch_reg     <= '0;
            strobe_reg <= 1'b0;
            open_reg   <= 1'b0;
            found_reg  <= 1'b0;
            hit0_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            iss_reg    <= iss_next;
            rv_reg     <= rv_next;
            rv_idx_reg <= rv_idx_next;
            ch_reg     <= ch_next;
            strobe_reg <= strobe_next;
            open_reg   <= open_next;
            found_reg  <= found_next;
            hit0_reg   <= hit0_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        base_reg   <= base_next;
        act0_reg   <= act0_next;
        period_reg <= period_next;
        prod_reg   <= prod_next;
        phase_reg  <= phase_next;
        prev_reg   <= prev_next;
        pv_reg     <= pv_next;
        nx_reg     <= nx_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        dmn_reg    <= dmn_next;
        m1_reg     <= m1_next;
        m2_reg     <= m2_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result strobe held for more than one cycle");

    a_invalid_black: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.color_valid) |->
            (result.out_red == 8'd0 && result.out_green == 8'd0 && result.out_blue == 8'd0))
        else $error("color reported on a result without update");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN1 || state_reg == ST_SCAN2) |-> !key_we)
        else $error("keyframe RAM written during a render scan");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_MOD_WAIT || state_reg == ST_BL_WAIT))
        else $error("divider finished with no sequencer waiting");

endmodule
